### src/corq_pkg.sv
// ----------------------------------------------------------------------------
// corq_pkg
// shared widths, request and status codes, and transaction types for the
// class-ordered request queue
// ----------------------------------------------------------------------------
package corq_pkg;

    // queue storage
    localparam int DEPTH         = 16;
    localparam int COUNT_W       = $clog2(DEPTH + 1);

    // field widths
    localparam int REQ_W         = 2;
    localparam int PATH_W        = 7;
    localparam int CLASS_W       = 2;
    localparam int STATION_W     = 16;
    localparam int MODULE_W      = 8;
    localparam int OWNER_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    // request fifo between front and back
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    // request type codes on the input channel
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;

    // internal operation codes after classification
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [PATH_W-1:0]    path;
        logic [CLASS_W-1:0]   cls;
        logic [STATION_W-1:0] station;
        logic [MODULE_W-1:0]  module_kind;
        logic [OWNER_W-1:0]   owner;
    } entry_t;

    typedef struct packed {
        logic [1:0] op;
        entry_t     entry;
    } req_t;

    typedef struct packed {
        logic                     ins;
        logic                     del;
    } action_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     head_valid;
        entry_t                   head;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } result_t;

endpackage

### src/corq_front.sv
// ----------------------------------------------------------------------------
// corq_front
// input register stage: takes request transactions and classifies them into
// internal operations for the request fifo
// ----------------------------------------------------------------------------
module corq_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [corq_pkg::REQ_W-1:0]       s_req_type,
    input  logic [corq_pkg::PATH_W-1:0]      s_path_number,
    input  logic [corq_pkg::CLASS_W-1:0]     s_priority_class,
    input  logic [corq_pkg::STATION_W-1:0]   s_station_id,
    input  logic [corq_pkg::MODULE_W-1:0]    s_module_kind,
    input  logic [corq_pkg::OWNER_W-1:0]     s_owner_id,
    output logic                             out_valid,
    input  logic                             out_ready,
    output corq_pkg::req_t                   out_req
);

    logic           hold_valid_reg, hold_valid_next;
    corq_pkg::req_t req_reg, req_next;
    logic           take;

    assign s_ready   = !hold_valid_reg || out_ready;
    assign take      = s_valid && s_ready;
    assign out_valid = hold_valid_reg;
    assign out_req   = req_reg;

    always_comb begin
        req_next                   = req_reg;
        hold_valid_next            = hold_valid_reg && !out_ready;
        if (take) begin
            hold_valid_next               = 1'b1;
            req_next.entry.path           = s_path_number;
            req_next.entry.cls            = s_priority_class;
            req_next.entry.station        = s_station_id;
            req_next.entry.module_kind    = s_module_kind;
            req_next.entry.owner          = s_owner_id;
            unique case (s_req_type)
                corq_pkg::REQ_INSERT: req_next.op = corq_pkg::OP_INSERT;
                corq_pkg::REQ_REMOVE: req_next.op = corq_pkg::OP_REMOVE;
                corq_pkg::REQ_POP:    req_next.op = corq_pkg::OP_POP;
                default:              req_next.op = corq_pkg::OP_NOP;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
    end

endmodule

### src/corq_req_fifo.sv
// ----------------------------------------------------------------------------
// corq_req_fifo
// short request fifo that decouples the front stage from the queue engine
// ----------------------------------------------------------------------------
module corq_req_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  corq_pkg::req_t in_req,
    output logic           out_valid,
    input  logic           out_ready,
    output corq_pkg::req_t out_req
);

    corq_pkg::req_t                   mem_reg [corq_pkg::FIFO_DEPTH];
    logic [corq_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [corq_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [corq_pkg::FIFO_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                             push, pop;

    assign in_ready  = (cnt_reg != corq_pkg::FIFO_CNT_W'(corq_pkg::FIFO_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_req   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == corq_pkg::FIFO_PTR_W'(corq_pkg::FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == corq_pkg::FIFO_PTR_W'(corq_pkg::FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

### src/corq_back.sv
// ----------------------------------------------------------------------------
// corq_back
// queue engine: a sorted array of entry cells with a two-step sequencer
// (decide, then shift) and the result output register
// ----------------------------------------------------------------------------
module corq_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_ready,
    input  corq_pkg::req_t    req,
    output logic              m_valid,
    input  logic              m_ready,
    output corq_pkg::result_t m_result
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CALC  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]                        state_reg, state_next;
    corq_pkg::entry_t                  cells_reg [corq_pkg::DEPTH];
    corq_pkg::entry_t                  cells_next [corq_pkg::DEPTH];
    logic [corq_pkg::COUNT_W-1:0]      count_reg, count_next;
    corq_pkg::req_t                    req_reg;

    logic [corq_pkg::DEPTH-1:0]        le_reg, mask_reg;
    corq_pkg::action_t                 act_reg;
    logic [corq_pkg::STATUS_W-1:0]     status_reg;

    logic                              out_valid_reg, out_valid_next;
    corq_pkg::result_t                 result_reg, result_next;

    // decision logic
    logic [corq_pkg::DEPTH-1:0]        valid_vec, le_vec, match_vec, cls_vec;
    logic [corq_pkg::DEPTH-1:0]        first_vec, del_onehot, mask_calc;
    logic                              cls_hit;
    corq_pkg::action_t                 act_calc;
    logic [corq_pkg::STATUS_W-1:0]     status_calc;

    logic                              take, out_free, commit;

    assign out_free  = !out_valid_reg || m_ready;
    assign commit    = (state_reg == S_APPLY) && out_free;
    assign req_ready = (state_reg == S_IDLE) || commit;
    assign take      = req_valid && req_ready;
    assign m_valid   = out_valid_reg;
    assign m_result  = result_reg;

    always_comb begin
        for (int i = 0; i < corq_pkg::DEPTH; i++) begin
            valid_vec[i] = (corq_pkg::COUNT_W'(i) < count_reg);
            le_vec[i]    = valid_vec[i] && (cells_reg[i].cls <= req_reg.entry.cls);
            match_vec[i] = valid_vec[i] && (cells_reg[i].path == req_reg.entry.path);
            cls_vec[i]   = (cells_reg[i].cls == req_reg.entry.cls);
        end
        // isolate the earliest entry with a matching path
        first_vec = match_vec & (~match_vec + corq_pkg::DEPTH'(1));
        cls_hit   = |(first_vec & cls_vec);

        act_calc    = '0;
        status_calc = corq_pkg::ST_DONE;
        del_onehot  = '0;
        unique case (req_reg.op)
            corq_pkg::OP_INSERT: begin
                if (count_reg == corq_pkg::COUNT_W'(corq_pkg::DEPTH)) begin
                    status_calc = corq_pkg::ST_FULL;
                end else begin
                    act_calc.ins = 1'b1;
                end
            end
            corq_pkg::OP_REMOVE: begin
                if (count_reg == '0) begin
                    status_calc = corq_pkg::ST_EMPTY;
                end else if (!cls_hit) begin
                    status_calc = corq_pkg::ST_NOT_FOUND;
                end else begin
                    act_calc.del = 1'b1;
                    del_onehot   = first_vec;
                end
            end
            corq_pkg::OP_POP: begin
                if (count_reg == '0) begin
                    status_calc = corq_pkg::ST_EMPTY;
                end else begin
                    act_calc.del = 1'b1;
                    del_onehot   = corq_pkg::DEPTH'(1);
                end
            end
            default: begin
                status_calc = corq_pkg::ST_DONE;
            end
        endcase
        // cells at and above the removed slot pull from their upper neighbor
        mask_calc = ~(del_onehot - corq_pkg::DEPTH'(1));
    end

    // shift network of the cell array
    always_comb begin
        for (int i = 0; i < corq_pkg::DEPTH; i++) begin
            cells_next[i] = cells_reg[i];
        end
        count_next = count_reg;
        if (commit) begin
            if (act_reg.ins) begin
                // entries of class <= new class form a prefix; insert right after it
                if (!le_reg[0]) begin
                    cells_next[0] = req_reg.entry;
                end
                for (int i = 1; i < corq_pkg::DEPTH; i++) begin
                    if (!le_reg[i]) begin
                        cells_next[i] = le_reg[i-1] ? req_reg.entry : cells_reg[i-1];
                    end
                end
                count_next = count_reg + 1'b1;
            end else if (act_reg.del) begin
                for (int i = 0; i < corq_pkg::DEPTH - 1; i++) begin
                    if (mask_reg[i]) begin
                        cells_next[i] = cells_reg[i+1];
                    end
                end
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_comb begin
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (commit) begin
            out_valid_next          = 1'b1;
            result_next.status      = status_reg;
            result_next.entry_count = corq_pkg::ENTRY_COUNT_W'(count_next);
            if (count_next != '0) begin
                result_next.head_valid = 1'b1;
                result_next.head       = cells_next[0];
            end else begin
                result_next.head_valid = 1'b0;
                result_next.head       = '0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (take) begin
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                state_next = S_APPLY;
            end
            S_APPLY: begin
                if (out_free) begin
                    state_next = take ? S_CALC : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            act_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_CALC) begin
                act_reg <= act_calc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < corq_pkg::DEPTH; i++) begin
            cells_reg[i] <= cells_next[i];
        end
        result_reg <= result_next;
        if (take) begin
            req_reg <= req;
        end
        if (state_reg == S_CALC) begin
            le_reg     <= le_vec;
            mask_reg   <= mask_calc;
            status_reg <= status_calc;
        end
    end

endmodule

### src/class_ordered_request_queue.sv
// ----------------------------------------------------------------------------
// class_ordered_request_queue
// ordered request queue: lower class first, arrival order within a class
// ----------------------------------------------------------------------------
// s_ channel carries one request per transaction: insert, remove by path and
// class, or pop head. every request yields exactly one m_ transaction with
// the status, the head entry after the operation and the entry count.
// requests pass an input register and a two-entry request fifo before the
// queue engine, so a stalled m_ side still lets a few requests be taken.
// the engine sequencer handles one request at a time: a decide state picks
// the slot, then an apply state shifts the cell array and commits the result;
// the next request is taken as the current one commits.
// the queue holds 16 entries; an insert into a full queue is dropped and
// reported with the full status.
// reset empties the queue; no clearing pass is needed, entries are read only
// below the fill count. while m_valid is high and m_ready low the result
// register holds and the engine waits with the next request not committed.
// ----------------------------------------------------------------------------
module class_ordered_request_queue (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [corq_pkg::REQ_W-1:0]           s_req_type,
    input  logic [corq_pkg::PATH_W-1:0]          s_path_number,
    input  logic [corq_pkg::CLASS_W-1:0]         s_priority_class,
    input  logic [corq_pkg::STATION_W-1:0]       s_station_id,
    input  logic [corq_pkg::MODULE_W-1:0]        s_module_kind,
    input  logic [corq_pkg::OWNER_W-1:0]         s_owner_id,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [corq_pkg::STATUS_W-1:0]        m_status,
    output logic                                 m_head_valid,
    output logic [corq_pkg::PATH_W-1:0]          m_head_path,
    output logic [corq_pkg::CLASS_W-1:0]         m_head_class,
    output logic [corq_pkg::STATION_W-1:0]       m_head_station,
    output logic [corq_pkg::MODULE_W-1:0]        m_head_module,
    output logic [corq_pkg::OWNER_W-1:0]         m_head_owner,
    output logic [corq_pkg::ENTRY_COUNT_W-1:0]   m_entry_count
);

    logic              front_valid, front_ready;
    corq_pkg::req_t    front_req;
    logic              fifo_valid, fifo_ready;
    corq_pkg::req_t    fifo_req;
    corq_pkg::result_t result;

    corq_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_path_number    (s_path_number),
        .s_priority_class (s_priority_class),
        .s_station_id     (s_station_id),
        .s_module_kind    (s_module_kind),
        .s_owner_id       (s_owner_id),
        .out_valid        (front_valid),
        .out_ready        (front_ready),
        .out_req          (front_req)
    );

    corq_req_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_req    (front_req),
        .out_valid (fifo_valid),
        .out_ready (fifo_ready),
        .out_req   (fifo_req)
    );

    corq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (fifo_valid),
        .req_ready (fifo_ready),
        .req       (fifo_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (result)
    );

    assign m_status       = result.status;
    assign m_head_valid   = result.head_valid;
    assign m_head_path    = result.head.path;
    assign m_head_class   = result.head.cls;
    assign m_head_station = result.head.station;
    assign m_head_module  = result.head.module_kind;
    assign m_head_owner   = result.head.owner;
    assign m_entry_count  = result.entry_count;

    // count never exceeds the queue depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entry_count <= corq_pkg::ENTRY_COUNT_W'(corq_pkg::DEPTH)))
        else $error("entry count above queue depth");

    // head valid agrees with the count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_head_valid == (m_entry_count != '0)))
        else $error("head valid disagrees with entry count");

    // a dropped insert only happens at full depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == corq_pkg::ST_FULL))
        |-> (m_entry_count == corq_pkg::ENTRY_COUNT_W'(corq_pkg::DEPTH)))
        else $error("full status with free slots");

    // empty status leaves the queue empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == corq_pkg::ST_EMPTY)) |-> (m_entry_count == '0))
        else $error("empty status with entries present");

endmodule

### bench/class_ordered_request_queue_test.sv
// ----------------------------------------------------------------------------
// class_ordered_request_queue_test
// self-checking bench for the class-ordered request queue
// ----------------------------------------------------------------------------
// a clocked driver offers requests from a pending list and a clocked monitor
// checks every result, field by field, against a behavioral copy of the
// queue. a short directed list covers the empty, full and not-found cases
// and the field extremes. it is followed by random phases that push the fill
// level up and down. both sides idle at random, and some stretches run
// without idling. the receiver is held off long enough to back up the block,
// and the sender waits for the block to drain before each phase.
// ----------------------------------------------------------------------------
module class_ordered_request_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 175;
    localparam int TAIL_CYCLES    = 20;
    localparam int PRINT_CAP      = 40;

    localparam logic [corq_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [corq_pkg::REQ_W-1:0]     req;
        logic [corq_pkg::PATH_W-1:0]    path;
        logic [corq_pkg::CLASS_W-1:0]   cls;
        logic [corq_pkg::STATION_W-1:0] station;
        logic [corq_pkg::MODULE_W-1:0]  kind;
        logic [corq_pkg::OWNER_W-1:0]   owner;
        int                             gap;
        bit                             wait_drain;
        bit                             hold_rx;
        bit                             rx_idle;
    } request_item_t;

    logic                               aclk             = 1'b0;
    logic                               aresetn          = 1'b0;
    logic                               s_valid          = 1'b0;
    logic                               s_ready;
    logic [corq_pkg::REQ_W-1:0]         s_req_type       = '0;
    logic [corq_pkg::PATH_W-1:0]        s_path_number    = '0;
    logic [corq_pkg::CLASS_W-1:0]       s_priority_class = '0;
    logic [corq_pkg::STATION_W-1:0]     s_station_id     = '0;
    logic [corq_pkg::MODULE_W-1:0]      s_module_kind    = '0;
    logic [corq_pkg::OWNER_W-1:0]       s_owner_id       = '0;
    logic                               m_valid;
    logic                               m_ready          = 1'b0;
    logic [corq_pkg::STATUS_W-1:0]      m_status;
    logic                               m_head_valid;
    logic [corq_pkg::PATH_W-1:0]        m_head_path;
    logic [corq_pkg::CLASS_W-1:0]       m_head_class;
    logic [corq_pkg::STATION_W-1:0]     m_head_station;
    logic [corq_pkg::MODULE_W-1:0]      m_head_module;
    logic [corq_pkg::OWNER_W-1:0]       m_head_owner;
    logic [corq_pkg::ENTRY_COUNT_W-1:0] m_entry_count;

    // model of the queue contents, slot 0 is the head
    corq_pkg::entry_t  queue_slots [corq_pkg::DEPTH];
    int                queue_fill = 0;
    int                peak_fill = 0;
    int                req_seen [4];
    int                status_seen [4];

    request_item_t     pending_requests [$];
    corq_pkg::result_t expected_results [$];

    request_item_t drv_item;
    request_item_t next_item;
    bit            have_next = 1'b0;
    bit            drv_accepted;
    bit            drv_offer;
    int            gap_left = 0;
    int            requests_done = 0;
    int            results_checked = 0;
    int            mismatch_count = 0;
    int            hold_req_cnt = 0;
    int            hold_seen = 0;
    int            rx_hold_left = 0;
    int            rx_gap = 0;
    bit            rx_idle_en = 1'b0;
    bit            rdy;
    int            cycle_count = 0;

    class_ordered_request_queue u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_path_number    (s_path_number),
        .s_priority_class (s_priority_class),
        .s_station_id     (s_station_id),
        .s_module_kind    (s_module_kind),
        .s_owner_id       (s_owner_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_head_valid     (m_head_valid),
        .m_head_path      (m_head_path),
        .m_head_class     (m_head_class),
        .m_head_station   (m_head_station),
        .m_head_module    (m_head_module),
        .m_head_owner     (m_head_owner),
        .m_entry_count    (m_entry_count)
    );

    always #6 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic request_item_t make_item(logic [corq_pkg::REQ_W-1:0] req,
                                                logic [corq_pkg::PATH_W-1:0] path,
                                                logic [corq_pkg::CLASS_W-1:0] cls,
                                                logic [corq_pkg::STATION_W-1:0] station,
                                                logic [corq_pkg::MODULE_W-1:0] kind,
                                                logic [corq_pkg::OWNER_W-1:0] owner);
        request_item_t it;
        it.req        = req;
        it.path       = path;
        it.cls        = cls;
        it.station    = station;
        it.kind       = kind;
        it.owner      = owner;
        it.gap        = 0;
        it.wait_drain = 1'b0;
        it.hold_rx    = 1'b0;
        it.rx_idle    = 1'b0;
        return it;
    endfunction

    // request of the given type with every field drawn over its full range
    function automatic request_item_t random_item(logic [corq_pkg::REQ_W-1:0] req);
        return make_item(req,
                         corq_pkg::PATH_W'($urandom_range(0, 127)),
                         corq_pkg::CLASS_W'($urandom_range(0, 3)),
                         corq_pkg::STATION_W'($urandom_range(0, 65535)),
                         corq_pkg::MODULE_W'($urandom_range(0, 255)),
                         $urandom);
    endfunction

    // applies one request to the queue model and returns the head report
    function automatic corq_pkg::result_t apply_request(request_item_t it);
        corq_pkg::result_t             r;
        corq_pkg::entry_t              e;
        int                            pos;
        logic [corq_pkg::STATUS_W-1:0] st;
        st            = corq_pkg::ST_DONE;
        e.path        = it.path;
        e.cls         = it.cls;
        e.station     = it.station;
        e.module_kind = it.kind;
        e.owner       = it.owner;
        case (it.req)
            corq_pkg::REQ_INSERT: begin
                if (queue_fill >= corq_pkg::DEPTH) begin
                    st = corq_pkg::ST_FULL;
                end else begin
                    // goes behind every entry of the same or a lower class
                    pos = 0;
                    while (pos < queue_fill && queue_slots[pos].cls <= it.cls) pos++;
                    for (int i = queue_fill; i > pos; i--) queue_slots[i] = queue_slots[i-1];
                    queue_slots[pos] = e;
                    queue_fill++;
                end
            end
            corq_pkg::REQ_REMOVE: begin
                if (queue_fill == 0) begin
                    st = corq_pkg::ST_EMPTY;
                end else begin
                    // only the earliest entry with this path is considered
                    pos = 0;
                    while (pos < queue_fill && queue_slots[pos].path != it.path) pos++;
                    if (pos >= queue_fill || queue_slots[pos].cls != it.cls) begin
                        st = corq_pkg::ST_NOT_FOUND;
                    end else begin
                        for (int i = pos; i < queue_fill - 1; i++) queue_slots[i] = queue_slots[i+1];
                        queue_fill--;
                    end
                end
            end
            corq_pkg::REQ_POP: begin
                if (queue_fill == 0) begin
                    st = corq_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i < queue_fill - 1; i++) queue_slots[i] = queue_slots[i+1];
                    queue_fill--;
                end
            end
            default: begin
            end
        endcase
        req_seen[it.req]++;
        status_seen[st]++;
        if (queue_fill > peak_fill) peak_fill = queue_fill;
        r.status      = st;
        r.head_valid  = (queue_fill > 0);
        r.head        = (queue_fill > 0) ? queue_slots[0] : '0;
        r.entry_count = corq_pkg::ENTRY_COUNT_W'(queue_fill);
        return r;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("[%0t] result %0d: %s got 0x%0h want 0x%0h",
                     $time, results_checked, field, got, want);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            drv_accepted = s_valid && s_ready;
            if (drv_accepted) begin
                expected_results.push_back(apply_request(drv_item));
                requests_done <= requests_done + 1;
                rx_idle_en    <= drv_item.rx_idle;
                if (drv_item.hold_rx) hold_req_cnt <= hold_req_cnt + 1;
            end
            if (drv_accepted || !s_valid) begin
                drv_offer = 1'b0;
                if (!have_next && pending_requests.size() != 0) begin
                    next_item = pending_requests.pop_front();
                    have_next = 1'b1;
                    gap_left  = next_item.gap;
                end
                if (have_next) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else if (!next_item.wait_drain ||
                                 (!drv_accepted && requests_done == results_checked)) begin
                        drv_item         = next_item;
                        have_next        = 1'b0;
                        drv_offer        = 1'b1;
                        s_req_type       <= next_item.req;
                        s_path_number    <= next_item.path;
                        s_priority_class <= next_item.cls;
                        s_station_id     <= next_item.station;
                        s_module_kind    <= next_item.kind;
                        s_owner_id       <= next_item.owner;
                    end
                end
                s_valid <= drv_offer;
            end
        end
    end

    // receiver ready, with random gaps and the long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            rx_gap       = 0;
            rx_hold_left = 0;
            hold_seen    = 0;
        end else begin
            rdy = 1'b1;
            if (hold_seen != hold_req_cnt) begin
                hold_seen    = hold_req_cnt;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                rdy = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                rdy = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                rx_gap = pick_gap() - 1;
                rdy    = 1'b0;
            end
            m_ready <= rdy;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction, status", m_status, 0);
            end else begin
                corq_pkg::result_t want;
                want = expected_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_head_valid !== want.head_valid)
                    report_mismatch("head_valid", m_head_valid, want.head_valid);
                if (m_head_path !== want.head.path)
                    report_mismatch("head_path", m_head_path, want.head.path);
                if (m_head_class !== want.head.cls)
                    report_mismatch("head_class", m_head_class, want.head.cls);
                if (m_head_station !== want.head.station)
                    report_mismatch("head_station", m_head_station, want.head.station);
                if (m_head_module !== want.head.module_kind)
                    report_mismatch("head_module", m_head_module, want.head.module_kind);
                if (m_head_owner !== want.head.owner)
                    report_mismatch("head_owner", m_head_owner, want.head.owner);
                if (m_entry_count !== want.entry_count)
                    report_mismatch("entry_count", m_entry_count, want.entry_count);
            end
            results_checked <= results_checked + 1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("class_ordered_request_queue: mismatch");
            $finish;
        end
    end

    initial begin
        request_item_t      it;
        logic [8:0]         recent_keys [$];
        logic [8:0]         k;
        int                 r;
        int                 ins_pct;
        bit                 idle;
        bit                 stall;

        for (int i = 0; i < 4; i++) begin
            req_seen[i]    = 0;
            status_seen[i] = 0;
        end

        // directed: empty queue first
        pending_requests.push_back(make_item(corq_pkg::REQ_POP, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_item(corq_pkg::REQ_REMOVE, 127, 3, 16'hffff, 8'hff, '1));
        pending_requests.push_back(make_item(REQ_UNUSED, 127, 3, 16'hffff, 8'hff, '1));
        pending_requests.push_back(make_item(corq_pkg::REQ_INSERT, 127, 3, 16'hffff, 8'hff, '1));
        pending_requests.push_back(make_item(corq_pkg::REQ_INSERT, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_item(corq_pkg::REQ_INSERT, 99, 2, 16'h1234, 8'h5a,
                                             32'ha5a5a5a5));
        // same path as the class 3 entry but sorted ahead of it
        pending_requests.push_back(make_item(corq_pkg::REQ_INSERT, 127, 0, 16'h8001, 8'h81,
                                             32'h80000001));
        pending_requests.push_back(make_item(corq_pkg::REQ_INSERT, 42, 1, 16'h00ff, 8'h0f,
                                             32'h0000ffff));
        pending_requests.push_back(make_item(corq_pkg::REQ_REMOVE, 100, 0, 0, 0, 0));
        // earliest path 127 is class 0, so this misses
        pending_requests.push_back(make_item(corq_pkg::REQ_REMOVE, 127, 3, 0, 0, 0));
        pending_requests.push_back(make_item(corq_pkg::REQ_REMOVE, 99, 2, 0, 0, 0));
        pending_requests.push_back(make_item(REQ_UNUSED, 5, 1, 16'h5555, 8'h55, 32'h55555555));
        pending_requests.push_back(make_item(corq_pkg::REQ_POP, 127, 3, 16'hffff, 8'hff, '1));
        // fill up, then one insert too many
        for (int i = 0; i < 14; i++) begin
            pending_requests.push_back(make_item(corq_pkg::REQ_INSERT,
                                                 corq_pkg::PATH_W'(i + 10),
                                                 corq_pkg::CLASS_W'(i % 4),
                                                 corq_pkg::STATION_W'($urandom_range(0, 65535)),
                                                 corq_pkg::MODULE_W'($urandom_range(0, 255)),
                                                 $urandom));
        end

        for (int p = 1; p <= PHASES; p++) begin
            case (p % 3)
                1: ins_pct = 65;
                2: ins_pct = 40;
                default: ins_pct = 25;
            endcase
            idle  = !(p == 1 || p == 4);
            stall = (p == 3 || p == 6);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    it = random_item(REQ_UNUSED);
                end else if (r < ins_pct) begin
                    // small path pool so that duplicates and hits are common
                    it = random_item(corq_pkg::REQ_INSERT);
                    if ($urandom_range(0, 99) < 80) it.path = corq_pkg::PATH_W'($urandom_range(0, 15));
                    recent_keys.push_back({it.path, it.cls});
                    if (recent_keys.size() > 32) void'(recent_keys.pop_front());
                end else if (r < ins_pct + (100 - ins_pct) * 6 / 10) begin
                    it = random_item(corq_pkg::REQ_REMOVE);
                    if (recent_keys.size() != 0 && $urandom_range(0, 99) < 75) begin
                        k       = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                        it.path = k[8:2];
                        it.cls  = k[1:0];
                        if ($urandom_range(0, 99) < 15)
                            it.cls = it.cls ^ corq_pkg::CLASS_W'($urandom_range(1, 3));
                    end
                end else begin
                    it = random_item(corq_pkg::REQ_POP);
                end
                it.rx_idle    = idle;
                it.wait_drain = (j == 0);
                it.hold_rx    = stall && (j == 0);
                // keep the sender busy while the receiver is held off
                if (idle && !(stall && j < 40) && $urandom_range(0, 99) < 30) it.gap = pick_gap();
                pending_requests.push_back(it);
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || have_next || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("ran %0d requests: %0d insert, %0d remove, %0d pop, %0d undefined; peak fill %0d",
                 requests_done, req_seen[corq_pkg::REQ_INSERT], req_seen[corq_pkg::REQ_REMOVE],
                 req_seen[corq_pkg::REQ_POP], req_seen[REQ_UNUSED], peak_fill);
        $display("status counts: done %0d, full %0d, not found %0d, empty %0d; %0d mismatches",
                 status_seen[corq_pkg::ST_DONE], status_seen[corq_pkg::ST_FULL],
                 status_seen[corq_pkg::ST_NOT_FOUND], status_seen[corq_pkg::ST_EMPTY],
                 mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("class_ordered_request_queue: match");
        end else begin
            $display("class_ordered_request_queue: mismatch");
        end
        $finish;
    end

endmodule
